// ----- hdl/rbst_pkg.sv -----
// shared constants and types for the ray box slab test unit
package rbst_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned HIT_WIDTH       = 31;
  localparam int unsigned CFG_IDX_WIDTH   = 3;
  localparam int unsigned HIT_SCALE       = 1000;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_MIN_X   = 3'd0,
    REG_MIN_Y   = 3'd1,
    REG_MIN_Z   = 3'd2,
    REG_MAX_X   = 3'd3,
    REG_MAX_Y   = 3'd4,
    REG_MAX_Z   = 3'd5,
    REG_HIT_INT = 3'd6
  } rbst_reg_e;

  typedef struct packed {
    logic [5:0] neg;
    logic [2:0] zero;
    logic [2:0] inslab;
  } rbst_side_t;

endpackage

// ----- hdl/rbst_if.sv -----
// ray and hit channel interfaces
interface rbst_ray_if #(
  parameter int unsigned CW = 32
);
  logic          valid;
  logic          ready;
  logic signed [CW-1:0] origin_x;
  logic signed [CW-1:0] origin_y;
  logic signed [CW-1:0] origin_z;
  logic signed [CW-1:0] dir_x;
  logic signed [CW-1:0] dir_y;
  logic signed [CW-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rbst_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

// ----- hdl/rbst_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module rbst_div #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CW:0]          num_i,
  input  logic [CW-1:0]        den_i,
  output logic [CW+FB:0]       quo_o
);

  localparam int unsigned QW = CW + FB + 1;

  logic [QW-1:0] dvd_q [QW];
  logic [CW-1:0] den_q [QW];
  logic [CW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0] dvd_p;
    logic [CW-1:0] den_p;
    logic [CW-1:0] rem_p;
    logic [QW-1:0] quo_p;
    logic [CW:0]   rr;
    logic          ge;
    logic [CW:0]   diff;

    if (k == 0) begin : g_first
      assign dvd_p = {num_i, {FB{1'b0}}};
      assign den_p = den_i;
      assign rem_p = '0;
      assign quo_p = '0;
    end else begin : g_next
      assign dvd_p = dvd_q[k-1];
      assign den_p = den_q[k-1];
      assign rem_p = rem_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign rr   = {rem_p, dvd_p[QW-1-k]};
    assign ge   = rr >= {1'b0, den_p};
    assign diff = rr - {1'b0, den_p};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[k] <= dvd_p;
        den_q[k] <= den_p;
        rem_q[k] <= ge ? diff[CW-1:0] : rr[CW-1:0];
        quo_q[k] <= {quo_p[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ----- hdl/ray_box_slab_test_unit.sv -----
// ray against axis-aligned box, slab method, pipelined
// throughput: one ray per cycle while the hit channel is not stalled; each quotient bit is one divider stage
// a stalled hit beat holds the whole pipeline, nothing is dropped
// reset clears all valid bits and loads the default box and window
module ray_box_slab_test_unit import rbst_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [((COORD_WIDTH > HIT_WIDTH) ? COORD_WIDTH : HIT_WIDTH)-1:0] cfg_data_i,
  rbst_ray_if.sink                 ray_i,
  rbst_hit_if.source               hit_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned QW = COORD_WIDTH + FRAC_BITS + 1;
  localparam int unsigned TW = (CW + 2 > 33) ? CW + 2 : 33;
  localparam logic [QW-1:0] HALF = QW'(1) << (CW - 1);
  localparam logic signed [TW-1:0] HUGE = TW'(1) << (TW - 2);
  localparam logic signed [TW-1:0] SAT_HI = TW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [TW-1:0] SAT_LO = -(TW'(1) << (CW - 1));

  // configuration
  logic signed [CW-1:0]  bmin_q [3];
  logic signed [CW-1:0]  bmax_q [3];
  logic [HIT_WIDTH-1:0]  hint_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        bmin_q[a] <= '0;
        bmax_q[a] <= CW'(1) << FRAC_BITS;
      end
      hint_q <= HIT_WIDTH'(64'(HIT_SCALE) << FRAC_BITS);
    end else if (cfg_we_i) begin
      case (rbst_reg_e'(cfg_idx_i))
        REG_MIN_X:   bmin_q[0] <= cfg_data_i[CW-1:0];
        REG_MIN_Y:   bmin_q[1] <= cfg_data_i[CW-1:0];
        REG_MIN_Z:   bmin_q[2] <= cfg_data_i[CW-1:0];
        REG_MAX_X:   bmax_q[0] <= cfg_data_i[CW-1:0];
        REG_MAX_Y:   bmax_q[1] <= cfg_data_i[CW-1:0];
        REG_MAX_Z:   bmax_q[2] <= cfg_data_i[CW-1:0];
        REG_HIT_INT: hint_q    <= cfg_data_i[HIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  assign en          = !hit_o.valid || hit_o.ready;
  assign ray_i.ready = en;

  // stage 0: numerators, magnitudes, signs
  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];
  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.dir_x;
  assign dir[1] = ray_i.dir_y;
  assign dir[2] = ray_i.dir_z;

  logic [CW:0]   num_d [6];
  logic [CW-1:0] den_d [6];
  rbst_side_t    side_d;

  always_comb begin
    logic signed [CW:0] nn;
    logic signed [CW:0] nf;
    logic               dneg;
    for (int a = 0; a < 3; a++) begin
      dneg = dir[a][CW-1];
      nn = dneg ? ((CW+1)'(bmax_q[a]) - (CW+1)'(org[a]))
                : ((CW+1)'(bmin_q[a]) - (CW+1)'(org[a]));
      nf = dneg ? ((CW+1)'(bmin_q[a]) - (CW+1)'(org[a]))
                : ((CW+1)'(bmax_q[a]) - (CW+1)'(org[a]));
      num_d[a]   = nn[CW] ? (CW+1)'(-nn) : nn;
      num_d[a+3] = nf[CW] ? (CW+1)'(-nf) : nf;
      den_d[a]   = dneg ? CW'(-dir[a]) : dir[a];
      den_d[a+3] = den_d[a];
      side_d.neg[a]    = nn[CW] ^ dneg;
      side_d.neg[a+3]  = nf[CW] ^ dneg;
      side_d.zero[a]   = dir[a] == '0;
      side_d.inslab[a] = (bmin_q[a] <= org[a]) && (org[a] <= bmax_q[a]);
    end
  end

  logic          v0_q;
  logic [CW:0]   num_q [6];
  logic [CW-1:0] den_q [6];
  rbst_side_t    side0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= ray_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q   <= num_d;
      den_q   <= den_d;
      side0_q <= side_d;
    end
  end

  // divider lanes: near x y z, far x y z
  logic [QW-1:0] quo [6];
  for (genvar l = 0; l < 6; l++) begin : g_lane
    rbst_div #(.CW(CW), .FB(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[l]),
      .den_i (den_q[l]),
      .quo_o (quo[l])
    );
  end

  logic       sv_q   [QW];
  rbst_side_t side_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) sv_q[k] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= v0_q;
      for (int k = 1; k < QW; k++) sv_q[k] <= sv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side0_q;
      for (int k = 1; k < QW; k++) side_q[k] <= side_q[k-1];
    end
  end

  // stage 1: saturation and zero direction
  logic signed [TW-1:0] t_d [6];
  always_comb begin
    rbst_side_t s;
    logic       sat;
    s = side_q[QW-1];
    for (int l = 0; l < 6; l++) begin
      sat = quo[l] >= HALF;
      if (s.neg[l]) t_d[l] = sat ? SAT_LO : -TW'(quo[l]);
      else          t_d[l] = sat ? SAT_HI : TW'(quo[l]);
      if (s.zero[l % 3]) begin
        if (l < 3) t_d[l] = s.inslab[l % 3] ? -HUGE : HUGE;
        else       t_d[l] = s.inslab[l % 3] ? HUGE : -HUGE;
      end
    end
  end

  logic                 v1_q;
  logic signed [TW-1:0] t1_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= sv_q[QW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) t1_q <= t_d;
  end

  // stage 2: x and y intersection
  logic                 v2_q;
  logic                 miss2_q;
  logic signed [TW-1:0] n2_q, f2_q, nz2_q, fz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      miss2_q <= (t1_q[0] > t1_q[4]) || (t1_q[1] > t1_q[3]);
      n2_q    <= (t1_q[1] > t1_q[0]) ? t1_q[1] : t1_q[0];
      f2_q    <= (t1_q[4] < t1_q[3]) ? t1_q[4] : t1_q[3];
      nz2_q   <= t1_q[2];
      fz2_q   <= t1_q[5];
    end
  end

  // stage 3: z intersection and window
  logic                 miss3;
  logic signed [TW-1:0] n3, f3, hi;
  assign miss3 = miss2_q || (n2_q > fz2_q) || (nz2_q > f2_q);
  assign n3    = (nz2_q > n2_q) ? nz2_q : n2_q;
  assign f3    = (fz2_q < f2_q) ? fz2_q : f2_q;
  assign hi    = TW'(hint_q);

  logic vo_q;
  logic hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en) vo_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) hit_q <= !miss3 && (n3 < hi) && (f3 > -hi);
  end

  assign hit_o.valid = vo_q;
  assign hit_o.hit   = hit_q;

endmodule

// ----- hdl/rbst_checker.sv -----
// port-level assertions for the ray box slab test unit
module rbst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  // a stalled hit beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("hit beat dropped or changed under stall");

  // input is taken exactly when the output stage can move
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready == (!out_valid || out_ready))
    else $error("ray ready out of step with hit stall");

  // nothing comes out while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("hit beat during reset");

  // an empty output stage never stalls the ray input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("ray stalled with empty output");

  // a waiting ray beat stays offered
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |=> in_valid)
    else $error("ray beat withdrawn under stall");

endmodule

bind ray_box_slab_test_unit rbst_checker u_rbst_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (ray_i.valid),
  .in_ready  (ray_i.ready),
  .out_valid (hit_o.valid),
  .out_ready (hit_o.ready),
  .out_hit   (hit_o.hit)
);

// ----- sim/ray_box_slab_test_unit_test.sv -----
// testbench for the ray box slab test unit: predicts each hit beat and checks it
`timescale 1ns / 1ps
module ray_box_slab_test_unit_test;
  import rbst_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned LATENCY = CW + FB + 5;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam longint HUGE_DIST = 64'sd1 <<< 60;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] oz;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] dz;
  } ray_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_data_i = '0;

  rbst_ray_if #(.CW(CW)) ray_ch ();
  rbst_hit_if hit_ch ();

  ray_box_slab_test_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .ray_i(ray_ch.sink), .hit_o(hit_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  longint box_lo[3];
  longint box_hi[3];
  longint window;
  bit     hit_expected[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     stall_mode = 0;

  initial begin
    ray_ch.valid = 1'b0;
    {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z} = '0;
    {ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z} = '0;
    hit_ch.ready = 1'b0;
  end

  function automatic longint sat_div(longint num, longint den);
    longint nabs, dabs, q, lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    nabs = num < 0 ? -num : num;
    dabs = den < 0 ? -den : den;
    lim = 64'sd1 <<< (CW - 1);
    if ((nabs >>> (CW - 1)) >= dabs) q = lim;
    else q = (nabs <<< FB) / dabs;
    if (q > lim) q = lim;
    if (neg) return (q >= lim) ? -lim : -q;
    return (q >= lim) ? lim - 1 : q;
  endfunction

  function automatic void slab_range(int a, longint o, longint d, output longint tn,
                                     output longint tf);
    if (d == 0) begin
      if (box_lo[a] <= o && o <= box_hi[a]) begin
        tn = -HUGE_DIST; tf = HUGE_DIST;
      end else begin
        tn = HUGE_DIST; tf = -HUGE_DIST;
      end
    end else if (d < 0) begin
      tn = sat_div(box_hi[a] - o, d);
      tf = sat_div(box_lo[a] - o, d);
    end else begin
      tn = sat_div(box_lo[a] - o, d);
      tf = sat_div(box_hi[a] - o, d);
    end
  endfunction

  function automatic bit predict_hit(ray_t r);
    longint n0, f0, n1, f1;
    slab_range(0, longint'(r.ox), longint'(r.dx), n0, f0);
    slab_range(1, longint'(r.oy), longint'(r.dy), n1, f1);
    if (n0 > f1 || n1 > f0) return 1'b0;
    if (n1 > n0) n0 = n1;
    if (f1 < f0) f0 = f1;
    slab_range(2, longint'(r.oz), longint'(r.dz), n1, f1);
    if (n0 > f1 || n1 > f0) return 1'b0;
    if (n1 > n0) n0 = n1;
    if (f1 < f0) f0 = f1;
    return (n0 < window && f0 > -window);
  endfunction

  task automatic write_reg(rbst_reg_e idx, logic [CW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MIN_X, REG_MIN_Y, REG_MIN_Z: box_lo[idx] = longint'(signed'(val));
      REG_MAX_X, REG_MAX_Y, REG_MAX_Z: box_hi[idx - REG_MAX_X] = longint'(signed'(val));
      default: window = longint'(val[HIT_WIDTH-1:0]);
    endcase
  endtask

  task automatic set_box(longint lx, longint ly, longint lz, longint hx, longint hy,
                         longint hz, longint win);
    write_reg(REG_MIN_X, lx[CW-1:0]);
    write_reg(REG_MIN_Y, ly[CW-1:0]);
    write_reg(REG_MIN_Z, lz[CW-1:0]);
    write_reg(REG_MAX_X, hx[CW-1:0]);
    write_reg(REG_MAX_Y, hy[CW-1:0]);
    write_reg(REG_MAX_Z, hz[CW-1:0]);
    write_reg(REG_HIT_INT, win[CW-1:0]);
  endtask

  // one ray beat, valid held until accepted
  task automatic send_ray(ray_t r);
    ray_ch.valid <= 1'b1;
    {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z} <= {r.ox, r.oy, r.oz};
    {ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z} <= {r.dx, r.dy, r.dz};
    do @(posedge clk_i); while (!ray_ch.ready);
    hit_expected.push_back(predict_hit(r));
    @(negedge clk_i);
  endtask

  task automatic send_gap();
    ray_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(negedge clk_i);
  endtask

  task automatic drain();
    ray_ch.valid <= 1'b0;
    wait (hit_expected.size() == 0);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return 32'h7fff_ffff - $urandom_range(0, 2);
      3: return 32'($urandom_range(0, 3)) - 32'd1;
      default: return 32'($signed($urandom_range(0, 8 << FB)) - (3 <<< FB));
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
    r.dx = rand_coord(); r.dy = rand_coord(); r.dz = rand_coord();
    if ($urandom_range(0, 5) == 0) r.dx = '0;
    if ($urandom_range(0, 5) == 0) r.dy = '0;
    if ($urandom_range(0, 5) == 0) r.dz = '0;
    return r;
  endfunction

  // ray aimed from a random offset toward a point inside the box (its low corner if inverted)
  function automatic ray_t aimed_ray();
    ray_t r;
    longint p[3], o[3];
    for (int a = 0; a < 3; a++) begin
      p[a] = box_lo[a] + (box_hi[a] > box_lo[a] ?
             longint'($urandom()) % (box_hi[a] - box_lo[a] + 1) : 0);
      o[a] = longint'($signed($urandom_range(0, 16 << FB))) - (8 <<< FB);
    end
    r.ox = CW'(p[0] + o[0]); r.oy = CW'(p[1] + o[1]); r.oz = CW'(p[2] + o[2]);
    r.dx = CW'(-o[0]); r.dy = CW'(-o[1]); r.dz = CW'(-o[2]);
    return r;
  endfunction

  task automatic test_directed();
    ray_t r;
    r = '{ox: -(1 <<< FB), oy: 1 <<< (FB-1), oz: 1 <<< (FB-1), dx: 1 <<< FB, dy: 0, dz: 0};
    send_ray(r);
    r.dx = -(1 <<< FB); send_ray(r);
    r.ox = 1 <<< (FB-1); r.oy = 1 <<< FB; r.dx = 0; send_ray(r);
    r.oy = (1 <<< FB) + 1; send_ray(r);
    r.oy = 0; r.oz = 0; send_ray(r);
    r = '{ox: 32'h8000_0000, oy: 32'h8000_0000, oz: 32'h8000_0000,
          dx: 32'h7fff_ffff, dy: 32'h7fff_ffff, dz: 32'h7fff_ffff};
    send_ray(r);
    r = '{ox: 32'h7fff_ffff, oy: 32'h7fff_ffff, oz: 32'h7fff_ffff,
          dx: 32'h8000_0000, dy: 32'h8000_0000, dz: 32'h8000_0000};
    send_ray(r);
    r = '{ox: -(2000 <<< FB), oy: 1 <<< (FB-1), oz: 1 <<< (FB-1), dx: 1, dy: 0, dz: 0};
    send_ray(r);
    r.dx = 1 <<< FB; send_ray(r);
    r = '{ox: 3 <<< FB, oy: 3 <<< FB, oz: 3 <<< FB, dx: 1, dy: -1, dz: 1};
    send_ray(r);
    r = '{ox: 0, oy: 0, oz: 0, dx: 0, dy: 0, dz: 0};
    send_ray(r);
    r = '{ox: 0, oy: 0, oz: 0, dx: 1 <<< FB, dy: 1 <<< FB, dz: 1 <<< FB};
    send_ray(r);
    r = '{ox: 32'hffff_ffff, oy: 32'hffff_ffff, oz: 32'hffff_ffff,
          dx: 32'hffff_ffff, dy: 32'hffff_ffff, dz: 32'hffff_ffff};
    send_ray(r);
    drain();
  endtask

  task automatic test_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && count > 0; i++, count--)
        send_ray(($urandom_range(0, 9) < 6) ? aimed_ray() : rand_ray());
      send_gap();
    end
    drain();
  endtask

  task automatic test_inverted_box();
    set_box(1 <<< FB, 0, 0, 0, 1 <<< FB, 1 <<< FB, 1000 <<< FB);
    test_random(40);
  endtask

  task automatic test_extreme_box();
    set_box(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
            64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    test_random(120);
    set_box(-(4 <<< FB), -(2 <<< FB), 0, 4 <<< FB, 2 <<< FB, 8 <<< FB, 0);
    test_random(100);
    set_box(-(4 <<< FB), -(2 <<< FB), 0, 4 <<< FB, 2 <<< FB, 8 <<< FB, 1);
    test_random(100);
  endtask

  task automatic test_random_boxes();
    longint lo[3], hi[3];
    for (int k = 0; k < 4; k++) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = longint'($signed($urandom_range(0, 64 << FB))) - (32 <<< FB);
        hi[a] = lo[a] + longint'($urandom_range(0, 16 << FB));
      end
      set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
              longint'($urandom_range(0, 32'h7fff_ffff)));
      test_random(120);
    end
  endtask

  // hit checker
  always @(posedge clk_i) begin
    if (rst_ni && hit_ch.valid && hit_ch.ready) begin
      if (hit_expected.size() == 0) begin
        $error("hit beat with no ray outstanding: hit %0b", hit_ch.hit);
        errors++;
      end else begin
        bit e;
        e = hit_expected.pop_front();
        if (hit_ch.hit !== e) begin
          $error("hit mismatch: expected %0b actual %0b", e, hit_ch.hit);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: hit_ch.ready <= 1'b1;
      1: hit_ch.ready <= ($urandom_range(0, 3) != 0);
      2: hit_ch.ready <= ($urandom_range(0, 3) == 0);
      default: hit_ch.ready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    box_lo = '{0, 0, 0};
    box_hi = '{1 <<< FB, 1 <<< FB, 1 <<< FB};
    window = longint'(HIT_SCALE) <<< FB;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(200);
    test_inverted_box();
    test_extreme_box();
    test_random_boxes();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
